### rtl/modbus_rtu_frame_codec_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Modbus RTU frame codec
// Implication checks clocked on i_clk, held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_FRAME_CODEC_UNIT_MACROS_SVH
`define MODBUS_RTU_FRAME_CODEC_UNIT_MACROS_SVH

// same-cycle implication
`define MRFC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// next-cycle implication
`define MRFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

### rtl/mrfc_pkg.sv
// ----------------------------------------------------------------------------
// mrfc_pkg
// Types, constants and the CRC-16/MODBUS byte update for the frame codec.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mrfc_pkg;

    localparam int MAX_FRAME_BYTES = 256;
    localparam int MIN_FRAME_BYTES = 4;
    localparam int RX_CNT_W        = $clog2(MAX_FRAME_BYTES + 1);
    localparam int FRAME_HDR_BYTES = 6;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic CMD_SEND = 1'b0;
    localparam logic CMD_RX   = 1'b1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ADDR_MISM = 3'd1,
        ST_CRC_MISM  = 3'd2,
        ST_TOO_LONG  = 3'd3,
        ST_TOO_SHORT = 3'd4
    } t_status;

    typedef struct packed {
        logic       is_verdict;
        logic [7:0] tx_byte;
        t_status    status;
        logic       last;
    } t_result;

    // one byte through the reflected CRC, LSB first
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### rtl/modbus_rtu_frame_codec_unit.sv
// A received byte carrying the last mark pushes its verdict into the registered result queue.
// A send starts the frame sequencer, which queues one byte per cycle while the queue has room.
// Throughput: one rx byte per cycle unless stalled; a send holds the input (frame sequencer).
// Output holds two results, so input is taken while a finished result waits.
// Reset: synchronous, active low; clears the queue, sequencer, stored address and receive state.
// ----------------------------------------------------------------------------
// modbus_rtu_frame_codec_unit
// Modbus RTU master framing: builds request frames with CRC and checks replies.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "modbus_rtu_frame_codec_unit_macros.svh"

module modbus_rtu_frame_codec_unit
    import mrfc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_command,
    input  logic [7:0]  i_dev_address,
    input  logic [7:0]  i_function_code,
    input  logic [15:0] i_register_address,
    input  logic [15:0] i_register_value,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_rx_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_is_verdict,
    output logic [7:0]  o_tx_byte,
    output logic [2:0]  o_status,
    output logic        o_last
);

    // result queue, two entries
    t_result r_fifo [2];
    logic    r_wr_ptr, r_rd_ptr;
    logic [1:0] r_out_cnt, n_out_cnt;

    // send sequencer
    logic       r_tx_busy;
    logic [2:0] r_tx_idx;
    logic [7:0] r_frame [FRAME_HDR_BYTES];
    logic [15:0] r_tx_crc;
    logic [7:0] r_sent_address;

    // receive state
    logic [15:0]         r_rx_crc, n_rx_crc;
    logic [7:0]          r_held0, r_held1;
    logic [7:0]          r_first, n_first;
    logic [RX_CNT_W-1:0] r_rx_count, n_rx_count;
    logic                r_too_long, n_too_long;

    logic    acc, acc_send, acc_rx, pop, room, tx_push, verdict_push, push;
    logic [7:0] tx_b;
    t_status verdict;
    t_result push_data;

    assign o_out_valid = (r_out_cnt != 2'd0);
    assign o_in_stall  = r_tx_busy || (r_out_cnt == 2'd2);
    assign acc         = i_in_valid && !o_in_stall;
    assign acc_send    = acc && (i_command == CMD_SEND);
    assign acc_rx      = acc && (i_command == CMD_RX);
    assign pop         = o_out_valid && !i_out_stall;
    assign room        = (r_out_cnt != 2'd2) || pop;
    assign tx_push     = r_tx_busy && room;

    assign o_is_verdict = r_fifo[r_rd_ptr].is_verdict;
    assign o_tx_byte    = r_fifo[r_rd_ptr].tx_byte;
    assign o_status     = r_fifo[r_rd_ptr].status;
    assign o_last       = r_fifo[r_rd_ptr].last;

    always_comb begin
        case (r_tx_idx)
            3'd6:    tx_b = r_tx_crc[7:0];
            3'd7:    tx_b = r_tx_crc[15:8];
            default: tx_b = r_frame[r_tx_idx];
        endcase
    end

    // receive byte update; the two newest bytes are held back from the CRC
    always_comb begin
        n_first    = (r_rx_count == '0) ? i_rx_byte : r_first;
        n_rx_crc   = (r_rx_count >= RX_CNT_W'(2)) ? crc_update(r_rx_crc, r_held0) : r_rx_crc;
        n_too_long = r_too_long;
        n_rx_count = r_rx_count;
        if (r_rx_count >= RX_CNT_W'(MAX_FRAME_BYTES)) begin
            n_too_long = 1'b1;
        end else begin
            n_rx_count = r_rx_count + RX_CNT_W'(1);
        end

        if (n_too_long) begin
            verdict = ST_TOO_LONG;
        end else if (n_rx_count < RX_CNT_W'(MIN_FRAME_BYTES)) begin
            verdict = ST_TOO_SHORT;
        end else if (n_first != r_sent_address) begin
            verdict = ST_ADDR_MISM;
        end else if ({i_rx_byte, r_held1} != n_rx_crc) begin
            verdict = ST_CRC_MISM;
        end else begin
            verdict = ST_OK;
        end
    end

    assign verdict_push = acc_rx && i_rx_last;
    assign push         = tx_push || verdict_push;

    always_comb begin
        if (tx_push) begin
            push_data.is_verdict = 1'b0;
            push_data.tx_byte    = tx_b;
            push_data.status     = ST_OK;
            push_data.last       = (r_tx_idx == 3'd7);
        end else begin
            push_data.is_verdict = 1'b1;
            push_data.tx_byte    = 8'h00;
            push_data.status     = verdict;
            push_data.last       = 1'b1;
        end
    end

    always_comb begin
        case ({push, pop})
            2'b10:   n_out_cnt = r_out_cnt + 2'd1;
            2'b01:   n_out_cnt = r_out_cnt - 2'd1;
            default: n_out_cnt = r_out_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= push_data;
        end
        if (acc_send) begin
            r_frame[0] <= i_dev_address;
            r_frame[1] <= i_function_code;
            r_frame[2] <= i_register_address[15:8];
            r_frame[3] <= i_register_address[7:0];
            r_frame[4] <= i_register_value[15:8];
            r_frame[5] <= i_register_value[7:0];
        end
        if (!i_rst_n) begin
            r_wr_ptr       <= 1'b0;
            r_rd_ptr       <= 1'b0;
            r_out_cnt      <= 2'd0;
            r_tx_busy      <= 1'b0;
            r_tx_idx       <= 3'd0;
            r_tx_crc       <= CRC_INIT;
            r_sent_address <= 8'h00;
            r_rx_crc       <= CRC_INIT;
            r_held0        <= 8'h00;
            r_held1        <= 8'h00;
            r_first        <= 8'h00;
            r_rx_count     <= '0;
            r_too_long     <= 1'b0;
        end else begin
            r_out_cnt <= n_out_cnt;
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end

            if (acc_send) begin
                r_tx_busy      <= 1'b1;
                r_tx_idx       <= 3'd0;
                r_tx_crc       <= CRC_INIT;
                r_sent_address <= i_dev_address;
            end else if (tx_push) begin
                r_tx_idx <= r_tx_idx + 3'd1;
                if (r_tx_idx < 3'(FRAME_HDR_BYTES)) begin
                    r_tx_crc <= crc_update(r_tx_crc, tx_b);
                end
                if (r_tx_idx == 3'd7) begin
                    r_tx_busy <= 1'b0;
                end
            end

            if (acc_rx) begin
                if (i_rx_last) begin
                    r_rx_crc   <= CRC_INIT;
                    r_held0    <= 8'h00;
                    r_held1    <= 8'h00;
                    r_first    <= 8'h00;
                    r_rx_count <= '0;
                    r_too_long <= 1'b0;
                end else begin
                    r_rx_crc   <= n_rx_crc;
                    r_held0    <= r_held1;
                    r_held1    <= i_rx_byte;
                    r_first    <= n_first;
                    r_rx_count <= n_rx_count;
                    r_too_long <= n_too_long;
                end
            end
        end
    end

    `MRFC_ASSERT_NOW(a_queue_depth, 1'b1, r_out_cnt != 2'd3)
    `MRFC_ASSERT_NOW(a_single_producer, tx_push, !verdict_push)
    `MRFC_ASSERT_NEXT(a_send_starts, acc_send, r_tx_busy && (r_tx_idx == 3'd0))
    `MRFC_ASSERT_NOW(a_verdict_shape, o_out_valid && o_is_verdict, o_last && (o_tx_byte == 8'h00))
    `MRFC_ASSERT_NOW(a_count_bound, 1'b1, r_rx_count <= RX_CNT_W'(MAX_FRAME_BYTES))

endmodule

### bench/mrfc_frame_checker.sv
// ----------------------------------------------------------------------------
// mrfc_frame_checker
// Watches both channels of the Modbus RTU frame codec. It keeps its own model
// of the request framing and the reply checking. Every result transfer is
// compared field by field with the oldest result still due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mrfc_frame_checker
    import mrfc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_command,
    input  logic [7:0]  i_dev_address,
    input  logic [7:0]  i_function_code,
    input  logic [15:0] i_register_address,
    input  logic [15:0] i_register_value,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_rx_last,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_is_verdict,
    input  logic [7:0]  i_tx_byte,
    input  logic [2:0]  i_status,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending
);

    t_result             due_results[$];
    logic [7:0]          sent_addr;
    logic [15:0]         rx_crc;
    logic [7:0]          rx_hold [2];
    logic [7:0]          rx_head;
    logic [RX_CNT_W-1:0] rx_len;
    logic                rx_overrun;
    logic [7:0]          tx_frame [8];
    logic [15:0]         tx_crc;
    t_status             verdict;
    t_result             seen;
    t_result             want;
    int                  fail_count = 0;

    // reflected CRC-16, one bit per pass, LSB first
    function automatic logic [15:0] crc16_modbus(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    task automatic clear_rx();
        rx_crc     = CRC_INIT;
        rx_hold[0] = 8'h00;
        rx_hold[1] = 8'h00;
        rx_head    = 8'h00;
        rx_len     = '0;
        rx_overrun = 1'b0;
    endtask

    task automatic flag_result(input string why, input string wanted);
        if (fail_count < 10) begin
            $display("%s: expected %s, got verdict=%0d byte=%02h status=%0d last=%0d",
                     why, wanted, seen.is_verdict, seen.tx_byte, seen.status, seen.last);
        end
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            due_results.delete();
            sent_addr = 8'h00;
            clear_rx();
        end else begin
            if (i_in_valid && !i_in_stall) begin : codec_model
                if (i_command == CMD_SEND) begin
                    tx_frame[0] = i_dev_address;
                    tx_frame[1] = i_function_code;
                    tx_frame[2] = i_register_address[15:8];
                    tx_frame[3] = i_register_address[7:0];
                    tx_frame[4] = i_register_value[15:8];
                    tx_frame[5] = i_register_value[7:0];
                    tx_crc = CRC_INIT;
                    for (int k = 0; k < FRAME_HDR_BYTES; k++) begin
                        tx_crc = crc16_modbus(tx_crc, tx_frame[k]);
                    end
                    tx_frame[6] = tx_crc[7:0];
                    tx_frame[7] = tx_crc[15:8];
                    sent_addr = i_dev_address;
                    for (int k = 0; k < 8; k++) begin
                        due_results.push_back('{1'b0, tx_frame[k], ST_OK, k == 7});
                    end
                end else begin
                    if (rx_len == 0) rx_head = i_rx_byte;
                    // the two newest bytes are held back as the candidate CRC
                    if (rx_len >= 2) rx_crc = crc16_modbus(rx_crc, rx_hold[0]);
                    rx_hold[0] = rx_hold[1];
                    rx_hold[1] = i_rx_byte;
                    if (rx_len >= MAX_FRAME_BYTES) begin
                        rx_overrun = 1'b1;
                    end else begin
                        rx_len = rx_len + 1'b1;
                    end
                    if (i_rx_last) begin
                        if (rx_overrun) begin
                            verdict = ST_TOO_LONG;
                        end else if (rx_len < MIN_FRAME_BYTES) begin
                            verdict = ST_TOO_SHORT;
                        end else if (rx_head != sent_addr) begin
                            verdict = ST_ADDR_MISM;
                        end else if ({rx_hold[1], rx_hold[0]} != rx_crc) begin
                            verdict = ST_CRC_MISM;
                        end else begin
                            verdict = ST_OK;
                        end
                        due_results.push_back('{1'b1, 8'h00, verdict, 1'b1});
                        clear_rx();
                    end
                end
            end
            if (i_out_valid && !i_out_stall) begin
                seen = '{i_is_verdict, i_tx_byte, t_status'(i_status), i_last};
                if (due_results.size() == 0) begin
                    flag_result("result transfer with nothing due", "none");
                end else begin
                    want = due_results.pop_front();
                    if (seen != want) begin
                        flag_result("result mismatch",
                                    $sformatf("verdict=%0d byte=%02h status=%0d last=%0d",
                                              want.is_verdict, want.tx_byte, want.status,
                                              want.last));
                    end
                end
            end
        end
        o_pending    = due_results.size();
        o_fail_count = fail_count;
    end

endmodule

### bench/tb_modbus_rtu_frame_codec_unit.sv
// ----------------------------------------------------------------------------
// tb_modbus_rtu_frame_codec_unit
// Drives request sends and reply byte streams into the frame codec. The input
// side runs in bursts and the output side stalls at random. The checker
// beside the block predicts and compares every result transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_modbus_rtu_frame_codec_unit;
    import mrfc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk              = 1'b0;
    logic        i_rst_n            = 1'b0;
    logic        i_in_valid         = 1'b0;
    logic        i_command          = CMD_SEND;
    logic [7:0]  i_dev_address      = 8'h00;
    logic [7:0]  i_function_code    = 8'h00;
    logic [15:0] i_register_address = 16'h0000;
    logic [15:0] i_register_value   = 16'h0000;
    logic [7:0]  i_rx_byte          = 8'h00;
    logic        i_rx_last          = 1'b0;
    logic        i_out_stall        = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_is_verdict;
    logic [7:0]  o_tx_byte;
    logic [2:0]  o_status;
    logic        o_last;

    int          fail_count;
    int          pending;
    int          cycles;
    int          burst_left = 0;
    int          stall_left = 0;
    int          stall_mode = 0;
    int          item_count = 0;
    logic [7:0]  cur_addr   = 8'h00;
    logic [7:0]  frame_buf[$];
    logic [7:0]  echo_hdr[$];

    modbus_rtu_frame_codec_unit u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_command          (i_command),
        .i_dev_address      (i_dev_address),
        .i_function_code    (i_function_code),
        .i_register_address (i_register_address),
        .i_register_value   (i_register_value),
        .i_rx_byte          (i_rx_byte),
        .i_rx_last          (i_rx_last),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_is_verdict       (o_is_verdict),
        .o_tx_byte          (o_tx_byte),
        .o_status           (o_status),
        .o_last             (o_last)
    );

    mrfc_frame_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .i_in_stall         (o_in_stall),
        .i_command          (i_command),
        .i_dev_address      (i_dev_address),
        .i_function_code    (i_function_code),
        .i_register_address (i_register_address),
        .i_register_value   (i_register_value),
        .i_rx_byte          (i_rx_byte),
        .i_rx_last          (i_rx_last),
        .i_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .i_is_verdict       (o_is_verdict),
        .i_tx_byte          (o_tx_byte),
        .i_status           (o_status),
        .i_last             (o_last),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // receiver stall pattern: stretches of free flow, light, even and heavy stalling
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(8, 64);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 3) == 0);
            2:       i_out_stall <= ($urandom_range(0, 1) == 0);
            default: i_out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // one input transfer; valid stays high into the next item unless a gap is due
    task automatic push_item(input logic cmd, input logic [7:0] addr, input logic [7:0] func,
                             input logic [15:0] reg_no, input logic [15:0] reg_val,
                             input logic [7:0] rx_b, input logic rx_l);
        i_in_valid         <= 1'b1;
        i_command          <= cmd;
        i_dev_address      <= addr;
        i_function_code    <= func;
        i_register_address <= reg_no;
        i_register_value   <= reg_val;
        i_rx_byte          <= rx_b;
        i_rx_last          <= rx_l;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        item_count++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic push_send(input logic [7:0] addr, input logic [7:0] func,
                             input logic [15:0] reg_no, input logic [15:0] reg_val);
        cur_addr = addr;
        echo_hdr = '{addr, func, reg_no[15:8], reg_no[7:0], reg_val[15:8], reg_val[7:0]};
        push_item(CMD_SEND, addr, func, reg_no, reg_val, 8'($urandom), 1'($urandom));
    endtask

    task automatic push_rx(input logic [7:0] rx_b, input logic rx_l);
        push_item(CMD_RX, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                  rx_b, rx_l);
    endtask

    // append the CRC of the bytes in frame_buf, low byte first
    function automatic void seal_frame();
        logic [15:0] c;
        logic        lsb;
        c = CRC_INIT;
        foreach (frame_buf[i]) begin
            c = c ^ {8'h00, frame_buf[i]};
            for (int k = 0; k < 8; k++) begin
                lsb = c[0];
                c   = c >> 1;
                if (lsb) c = c ^ CRC_POLY;
            end
        end
        frame_buf.push_back(c[7:0]);
        frame_buf.push_back(c[15:8]);
    endfunction

    task automatic play_from(input int lo);
        for (int i = lo; i < frame_buf.size(); i++) begin
            push_rx(frame_buf[i], i == frame_buf.size() - 1);
        end
    endtask

    initial begin
        int pick;
        int split;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reply to address zero before any send: the stored address is still zero
        frame_buf = '{8'h00, 8'h03};
        seal_frame();
        play_from(0);

        push_send(8'hFF, 8'h00, 16'h0000, 16'hFFFF);
        push_send(8'h00, 8'hFF, 16'hFFFF, 16'h0000);
        push_send(8'h11, 8'h06, 16'h0001, 16'h0003);

        // write-single-register echo
        frame_buf = echo_hdr;
        seal_frame();
        play_from(0);

        // too short: one byte, then three
        frame_buf = '{8'h11};
        play_from(0);
        frame_buf = '{8'h11, 8'h06, 8'hAB};
        play_from(0);

        // shortest legal frame with a foreign address, then with a bad CRC
        frame_buf = '{8'h12, 8'h06};
        seal_frame();
        play_from(0);
        frame_buf = '{8'h11, 8'h06};
        seal_frame();
        frame_buf[3] = frame_buf[3] ^ 8'h01;
        play_from(0);

        // a send in the middle of a reply leaves the receive side alone
        frame_buf = '{8'h11, 8'h03, 8'h02, 8'h00, 8'h2A};
        seal_frame();
        push_rx(frame_buf[0], 1'b0);
        push_rx(frame_buf[1], 1'b0);
        push_send(8'h11, 8'h03, 16'h0010, 16'h0001);
        play_from(2);

        while (item_count < 150) begin
            if ($urandom_range(0, 2) == 0) begin
                push_send(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
            end
            pick = $urandom_range(0, 9);
            frame_buf.delete();
            case (pick)
                0, 1, 2, 3, 4: begin
                    frame_buf.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom) : cur_addr);
                    repeat ($urandom_range(1, 9)) frame_buf.push_back(8'($urandom));
                    seal_frame();
                    if ($urandom_range(0, 4) == 0) begin
                        split = $urandom_range(0, frame_buf.size() - 1);
                        frame_buf[split] = frame_buf[split] ^ 8'($urandom_range(1, 255));
                    end
                    play_from(0);
                end
                5: begin
                    frame_buf = echo_hdr;
                    seal_frame();
                    play_from(0);
                end
                6: begin
                    frame_buf.push_back(cur_addr);
                    repeat ($urandom_range(0, 2)) frame_buf.push_back(8'($urandom));
                    play_from(0);
                end
                7: begin
                    repeat ($urandom_range(1, 8)) push_rx(8'($urandom), $urandom_range(0, 3) == 0);
                end
                8: begin
                    frame_buf.push_back(cur_addr);
                    repeat ($urandom_range(1, 6)) frame_buf.push_back(8'($urandom));
                    seal_frame();
                    split = $urandom_range(1, frame_buf.size() - 1);
                    for (int i = 0; i < split; i++) push_rx(frame_buf[i], 1'b0);
                    push_send(cur_addr, 8'($urandom), 16'($urandom), 16'($urandom));
                    play_from(split);
                end
                default: begin
                    repeat ($urandom_range(4, 12)) frame_buf.push_back(8'($urandom));
                    play_from(0);
                end
            endcase
        end
        i_in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
